### hw/rtl/grid_best_first_path_search_macros.svh
// Assertion macros shared by the path search RTL.
// Depends on nothing; included by the top level.
`ifndef GRID_BEST_FIRST_PATH_SEARCH_MACROS_SVH
`define GRID_BEST_FIRST_PATH_SEARCH_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define GBF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define GBF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/gbfps_pkg.sv
// Shared types and constants for the grid path search.
// Depends on nothing.
package gbfps_pkg;

    localparam int GridWidthDef  = 8;
    localparam int GridHeightDef = 8;
    localparam int Cells         = 64;
    localparam int IdxW          = 6;
    localparam int GW            = 6;
    localparam int FW            = 8;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_EXP_RD,
        ST_EXP_WR,
        ST_SCAN,
        ST_SCAN_END,
        ST_TRACE,
        ST_EMIT,
        ST_FAIL
    } state_t;

    // Cell record kept in the node memory
    typedef struct packed {
        logic [GW-1:0]   g;
        logic [FW-1:0]   f;
        logic [IdxW-1:0] parent;
    } node_t;

    // Neighbor offsets, tried in order
    function automatic logic signed [1:0] nb_dx(input logic [2:0] k);
        case (k)
            3'd0, 3'd1: nb_dx = 2'sd1;
            3'd2, 3'd3: nb_dx = 2'sd0;
            default:    nb_dx = -2'sd1;
        endcase
    endfunction

    function automatic logic signed [1:0] nb_dy(input logic [2:0] k);
        nb_dy = k[0] ? -2'sd1 : 2'sd1;
    endfunction

endpackage

### hw/rtl/gbfps_node_mem.sv
// Node record memory (g, f, parent) with registered read.
// Depends on gbfps_pkg.
module gbfps_node_mem
(
    input  logic                        clk,
    input  logic                        we,
    input  logic [gbfps_pkg::IdxW-1:0]  waddr,
    input  gbfps_pkg::node_t            wdata,
    input  logic [gbfps_pkg::IdxW-1:0]  raddr,
    output gbfps_pkg::node_t            rdata
);
    gbfps_pkg::node_t mem [gbfps_pkg::Cells];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### hw/rtl/gbfps_map_mem.sv
// Free-cell map with valid bits cleared at reset; registered read.
// Depends on gbfps_pkg.
module gbfps_map_mem
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        we,
    input  logic [gbfps_pkg::IdxW-1:0]  waddr,
    input  logic                        wdata,
    input  logic [gbfps_pkg::IdxW-1:0]  raddr,
    output logic                        rdata
);
    logic [gbfps_pkg::Cells-1:0] free_reg;

    // Hold free bits; reset blocks every cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg <= '0;
            rdata    <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                free_reg[waddr] <= wdata;
            end
            rdata <= free_reg[raddr];
        end
    end
endmodule

### hw/rtl/grid_best_first_path_search.sv
// Top level of the grid best-first path search.
// Depends on gbfps_pkg, gbfps_node_mem, gbfps_map_mem and the macro header.
//
//  channel   dir  tdata                                       tuser  tlast
//  s_axis    in   cell_x/y, cell_free, start_x/y, goal_x/y     kind   -
//  m_axis    out  point_x, point_y                            found  last
//
// A cell write updates the map. A search clears open/closed marks and seeds the
// start node, then per expansion reads and updates each of the six neighbors and
// scans all 64 cells in turn for the open cell with the lowest f; the scan dominates.
// Path trace stores each point and fetches its parent, then one result per accepted beat.
// Reset clears control state and the map; output stalls hold the emitter.
`include "grid_best_first_path_search_macros.svh"
module grid_best_first_path_search
#(
    parameter int GRID_WIDTH  = gbfps_pkg::GridWidthDef,
    parameter int GRID_HEIGHT = gbfps_pkg::GridHeightDef
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cell_x, cell_y, cell_free, start_x, start_y, goal_x, goal_y; 5 pad
    input  logic [23:0] s_axis_tdata,
    // kind
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // point_x, point_y; 2 pad
    output logic [7:0]  m_axis_tdata,
    // found
    output logic        m_axis_tuser,
    output logic        m_axis_tlast
);
    localparam int IW = gbfps_pkg::IdxW;

    gbfps_pkg::state_t state_reg, state_next;

    logic [63:0]   open_reg, open_next, closed_reg, closed_next;
    logic [2:0]    sx_reg, sy_reg, gx_reg, gy_reg, sx_next, sy_next, gx_next, gy_next;
    logic [2:0]    cx_reg, cy_reg, cx_next, cy_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic [2:0]    k_reg, k_next;
    logic [IW-1:0] scan_reg, scan_next;
    logic [IW-1:0] best_reg, best_next;
    logic [7:0]    bf_reg, bf_next;
    logic          bv_reg, bv_next;
    logic [5:0]    curg_reg, curg_next;
    logic [IW-1:0] path_reg [64];
    logic [6:0]    n_reg, n_next;
    logic [IW-1:0] p_reg, p_next;
    logic          tv_reg, tv_next;
    logic [7:0]    td_reg, td_next;
    logic          tu_reg, tu_next;
    logic          tl_reg, tl_next;
    logic          pw_en;
    logic [IW-1:0] pw_data;
    logic [IW-1:0] nd_ra_q;

    // Node and map memories
    logic             nd_we, mp_we, mp_wd;
    logic [IW-1:0]    nd_wa, nd_ra, mp_wa, mp_ra;
    gbfps_pkg::node_t nd_wd, nd_rd;
    logic             mp_rd;

    gbfps_node_mem u_node (.clk(clk), .we(nd_we), .waddr(nd_wa), .wdata(nd_wd),
                           .raddr(nd_ra), .rdata(nd_rd));
    gbfps_map_mem u_map (.clk(clk), .rst_n(rst_n), .we(mp_we), .waddr(mp_wa),
                         .wdata(mp_wd), .raddr(mp_ra), .rdata(mp_rd));

    // Input fields
    logic       in_kind, in_free;
    logic [2:0] in_cx, in_cy, in_sx, in_sy, in_gx, in_gy;
    assign in_kind = s_axis_tuser;
    assign in_cx   = s_axis_tdata[2:0];
    assign in_cy   = s_axis_tdata[5:3];
    assign in_free = s_axis_tdata[6];
    assign in_sx   = s_axis_tdata[9:7];
    assign in_sy   = s_axis_tdata[12:10];
    assign in_gx   = s_axis_tdata[15:13];
    assign in_gy   = s_axis_tdata[18:16];

    // Cell address: row in the upper bits, column in the lower bits
    function automatic logic [IW-1:0] idx(input logic [2:0] x, input logic [2:0] y);
        idx = {y, x};
    endfunction

    // Neighbor coordinates
    logic signed [4:0] nx_s, ny_s;
    logic              nb_in;
    logic [2:0]        nx, ny;
    logic [IW-1:0]     nb_idx;
    logic signed [7:0] ddx, ddy;
    logic [7:0]        hval, fval;
    logic [5:0]        gval;
    assign nx_s  = 5'(signed'({2'b00, cx_reg})) + 5'(gbfps_pkg::nb_dx(k_reg));
    assign ny_s  = 5'(signed'({2'b00, cy_reg})) + 5'(gbfps_pkg::nb_dy(k_reg));
    assign nb_in = (nx_s >= 0) && (nx_s < 5'(GRID_WIDTH))
                && (ny_s >= 0) && (ny_s < 5'(GRID_HEIGHT));
    assign nx    = nx_s[2:0];
    assign ny    = ny_s[2:0];
    assign nb_idx = idx(nx, ny);
    assign ddx   = signed'({5'b00000, nx}) - signed'({5'b00000, gx_reg});
    assign ddy   = signed'({5'b00000, ny}) - signed'({5'b00000, gy_reg});
    assign hval  = 8'(ddx * ddx) + 8'(ddy * ddy);
    assign gval  = curg_reg + 6'd1;
    assign fval  = 8'({2'b00, gval}) + hval;

    logic at_goal, s_in, g_in;
    assign at_goal = (cx_reg == gx_reg) && (cy_reg == gy_reg);
    assign s_in = (32'(in_sx) < GRID_WIDTH) && (32'(in_sy) < GRID_HEIGHT);
    assign g_in = (32'(in_gx) < GRID_WIDTH) && (32'(in_gy) < GRID_HEIGHT);

    logic [IW-1:0] start_idx, goal_idx;
    assign start_idx = idx(sx_reg, sy_reg);
    assign goal_idx  = idx(gx_reg, gy_reg);

    logic out_free;
    assign out_free = !tv_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == gbfps_pkg::ST_IDLE);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        open_next = open_reg; closed_next = closed_reg;
        sx_next = sx_reg; sy_next = sy_reg; gx_next = gx_reg; gy_next = gy_reg;
        cx_next = cx_reg; cy_next = cy_reg; cur_next = cur_reg; k_next = k_reg;
        scan_next = scan_reg; best_next = best_reg; bf_next = bf_reg; bv_next = bv_reg;
        curg_next = curg_reg; n_next = n_reg; p_next = p_reg;
        tv_next = tv_reg; td_next = td_reg; tu_next = tu_reg; tl_next = tl_reg;
        nd_we = 1'b0; nd_wa = nb_idx; nd_wd = '0; nd_ra = nb_idx;
        mp_we = 1'b0; mp_wa = idx(in_cx, in_cy); mp_wd = in_free; mp_ra = nb_idx;
        pw_en = 1'b0; pw_data = p_reg;
        if (tv_reg && m_axis_tready)
        begin
            tv_next = 1'b0;
        end
        case (state_reg)
            gbfps_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (in_kind == gbfps_pkg::KIND_WRITE)
                    begin
                        mp_we = (32'(in_cx) < GRID_WIDTH) && (32'(in_cy) < GRID_HEIGHT);
                    end
                    else
                    begin
                        sx_next = in_sx; sy_next = in_sy; gx_next = in_gx; gy_next = in_gy;
                        state_next = (s_in && g_in) ? gbfps_pkg::ST_CLEAR
                                                    : gbfps_pkg::ST_FAIL;
                    end
                end
            end
            gbfps_pkg::ST_CLEAR:
            begin
                // drop marks, seed the start node
                open_next = '0;
                closed_next = '0;
                closed_next[start_idx] = 1'b1;
                nd_we = 1'b1; nd_wa = start_idx;
                nd_wd = '{g: '0, f: '0, parent: start_idx};
                cx_next = sx_reg; cy_next = sy_reg; cur_next = start_idx;
                curg_next = '0; k_next = '0;
                state_next = gbfps_pkg::ST_EXP_RD;
            end
            gbfps_pkg::ST_EXP_RD:
            begin
                nd_ra = nb_idx; mp_ra = nb_idx;
                state_next = gbfps_pkg::ST_EXP_WR;
            end
            gbfps_pkg::ST_EXP_WR:
            begin
                // update the neighbor when it improves
                if (nb_in && mp_rd && !closed_reg[nb_idx]
                    && (!open_reg[nb_idx] || fval < nd_rd.f))
                begin
                    open_next[nb_idx] = 1'b1;
                    nd_we = 1'b1; nd_wa = nb_idx;
                    nd_wd = '{g: gval, f: fval, parent: cur_reg};
                end
                k_next = k_reg + 3'd1;
                if (k_reg == 3'd5)
                begin
                    if (at_goal)
                    begin
                        p_next = goal_idx; n_next = '0;
                        state_next = gbfps_pkg::ST_TRACE;
                    end
                    else
                    begin
                        scan_next = '0; bv_next = 1'b0;
                        state_next = gbfps_pkg::ST_SCAN;
                    end
                end
                else
                begin
                    state_next = gbfps_pkg::ST_EXP_RD;
                end
            end
            gbfps_pkg::ST_SCAN:
            begin
                // x-outer scan order: scan = {x, y}; cells off the grid are never open
                nd_ra = idx(scan_reg[5:3], scan_reg[2:0]);
                state_next = gbfps_pkg::ST_SCAN_END;
            end
            gbfps_pkg::ST_SCAN_END:
            begin
                if (open_reg[nd_ra_q] && (!bv_reg || nd_rd.f < bf_reg))
                begin
                    bv_next = 1'b1; best_next = nd_ra_q; bf_next = nd_rd.f;
                    curg_next = nd_rd.g;
                end
                scan_next = scan_reg + 6'd1;
                if (scan_reg == 6'd63)
                begin
                    if (!bv_next)
                    begin
                        state_next = gbfps_pkg::ST_FAIL;
                    end
                    else
                    begin
                        cur_next = best_next;
                        cx_next = best_next[2:0];
                        cy_next = best_next[5:3];
                        open_next[best_next] = 1'b0;
                        closed_next[best_next] = 1'b1;
                        k_next = '0;
                        state_next = gbfps_pkg::ST_EXP_RD;
                    end
                end
                else
                begin
                    state_next = gbfps_pkg::ST_SCAN;
                end
            end
            gbfps_pkg::ST_TRACE:
            begin
                // push one point, fetch its parent
                if (k_reg[0] == 1'b0)
                begin
                    pw_en = 1'b1; pw_data = p_reg;
                    n_next = n_reg + 7'd1;
                    nd_ra = p_reg;
                    k_next = 3'd1;
                end
                else
                begin
                    k_next = 3'd0;
                    if (nd_rd.parent == start_idx || n_reg == 7'd64)
                    begin
                        state_next = gbfps_pkg::ST_EMIT;
                    end
                    else
                    begin
                        p_next = nd_rd.parent;
                    end
                end
            end
            gbfps_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    tv_next = 1'b1;
                    td_next = {2'b00, path_reg[n_reg[5:0] - 6'd1]};
                    tu_next = 1'b1;
                    tl_next = (n_reg == 7'd1);
                    n_next = n_reg - 7'd1;
                    if (n_reg == 7'd1)
                    begin
                        state_next = gbfps_pkg::ST_IDLE;
                    end
                end
            end
            gbfps_pkg::ST_FAIL:
            begin
                if (out_free)
                begin
                    tv_next = 1'b1; td_next = '0; tu_next = 1'b0; tl_next = 1'b1;
                    state_next = gbfps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gbfps_pkg::ST_IDLE;
            end
        endcase
    end

    // Registered scan address for the compare cycle, and path point storage
    always_ff @(posedge clk)
    begin
        nd_ra_q <= nd_ra;
        if (pw_en)
        begin
            path_reg[n_reg[5:0]] <= pw_data;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sx_reg <= sx_next; sy_reg <= sy_next; gx_reg <= gx_next; gy_reg <= gy_next;
        cx_reg <= cx_next; cy_reg <= cy_next; cur_reg <= cur_next;
        best_reg <= best_next; bf_reg <= bf_next; curg_reg <= curg_next;
        p_reg <= p_next; td_reg <= td_next; tu_reg <= tu_next; tl_reg <= tl_next;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gbfps_pkg::ST_IDLE;
            open_reg <= '0; closed_reg <= '0;
            k_reg <= '0; scan_reg <= '0; bv_reg <= 1'b0; n_reg <= '0; tv_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            open_reg <= open_next; closed_reg <= closed_next;
            k_reg <= k_next; scan_reg <= scan_next; bv_reg <= bv_next;
            n_reg <= n_next; tv_reg <= tv_next;
        end
    end

    assign m_axis_tvalid = tv_reg;
    assign m_axis_tdata  = td_reg;
    assign m_axis_tuser  = tu_reg;
    assign m_axis_tlast  = tl_reg;

    `GBF_ASSERT_IMP(a_no_open_closed, clk, rst_n, 1'b1, (open_reg & closed_reg) == '0,
        "cell both open and closed")
    `GBF_ASSERT_NEXT(a_out_hold, clk, rst_n, tv_reg && !m_axis_tready,
        tv_reg && $stable(td_reg), "result dropped under stall")
    `GBF_ASSERT_IMP(a_ready_idle, clk, rst_n, s_axis_tready,
        state_reg == gbfps_pkg::ST_IDLE, "request taken while busy")
endmodule

### dv/tb_top.sv
// Testbench for grid_best_first_path_search: grid writes and path searches.
// Depends on gbfps_pkg and the grid_best_first_path_search RTL.
// A local predictor computes expected path points; results are compared in order.
`timescale 1ns / 1ps
module tb_top;

    localparam int GRID_W     = 8;
    localparam int GRID_H     = 8;
    localparam int LIMIT_CYC  = 4000000;
    localparam int DIR_ROWS   = 20;

    typedef struct packed {
        logic [2:0] px;
        logic [2:0] py;
        logic       found;
        logic       last;
    } point_t;

    typedef struct packed {
        logic       kind;
        logic [2:0] cx;
        logic [2:0] cy;
        logic       free;
        logic [2:0] sx;
        logic [2:0] sy;
        logic [2:0] gx;
        logic [2:0] gy;
    } request_t;

    // one directed row; has_fixed marks a typed-in expected single result
    typedef struct {
        request_t req;
        bit       has_fixed;
        point_t   fixed;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    // predictor state
    bit          free_map [64];
    bit          open_m   [64];
    bit          closed_m [64];
    logic [5:0]  g_cost   [64];
    logic [7:0]  f_cost   [64];
    logic [5:0]  parent   [64];

    point_t      expected_points[$];
    int          errors;
    int          cycles;
    int          n_results;
    int          n_searches;
    int          n_found;
    row_t        dir_rows[DIR_ROWS];

    grid_best_first_path_search dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [23:0] pack_request(request_t r);
        return {5'b00000, r.gy, r.gx, r.sy, r.sx, r.free, r.cy, r.cx};
    endfunction

    // expand one cell's six neighbors toward the goal
    function automatic void relax_neighbors(int x, int y, int gx, int gy);
        int dxs[6];
        int dys[6];
        int nx;
        int ny;
        int n;
        int h;
        logic [5:0] g;
        logic [7:0] f;
        dxs = '{1, 1, 0, 0, -1, -1};
        dys = '{1, -1, 1, -1, 1, -1};
        for (int k = 0; k < 6; k++)
        begin
            nx = x + dxs[k];
            ny = y + dys[k];
            if (nx < 0 || nx >= GRID_W || ny < 0 || ny >= GRID_H)
                continue;
            n = ny * GRID_W + nx;
            if (!free_map[n] || closed_m[n])
                continue;
            g = g_cost[y * GRID_W + x] + 6'd1;
            h = (nx - gx) * (nx - gx) + (ny - gy) * (ny - gy);
            f = 8'(int'(g) + h);
            if (open_m[n] && f >= f_cost[n])
                continue;
            open_m[n] = 1;
            g_cost[n] = g;
            f_cost[n] = f;
            parent[n] = 6'(y * GRID_W + x);
        end
    endfunction

    // apply one request to the predictor and queue its path points
    function automatic void predict_path(request_t r);
        int cx;
        int cy;
        int bx;
        int by;
        int c;
        int start;
        int goal;
        int p;
        int npts;
        logic [7:0] bf;
        int pts[64];
        point_t pt;
        if (r.kind == gbfps_pkg::KIND_WRITE)
        begin
            free_map[r.cy * GRID_W + r.cx] = r.free;
            return;
        end
        n_searches++;
        foreach (open_m[i])
        begin
            open_m[i] = 0;
            closed_m[i] = 0;
        end
        start = r.sy * GRID_W + r.sx;
        goal = r.gy * GRID_W + r.gx;
        closed_m[start] = 1;
        g_cost[start] = 0;
        f_cost[start] = 0;
        parent[start] = 6'(start);
        cx = r.sx;
        cy = r.sy;
        relax_neighbors(cx, cy, r.gx, r.gy);
        while (!(cx == r.gx && cy == r.gy))
        begin
            bx = -1;
            by = -1;
            bf = 0;
            for (int x = 0; x < GRID_W; x++)
                for (int y = 0; y < GRID_H; y++)
                begin
                    c = y * GRID_W + x;
                    if (open_m[c] && (bx < 0 || f_cost[c] < bf))
                    begin
                        bx = x;
                        by = y;
                        bf = f_cost[c];
                    end
                end
            if (bx < 0)
                break;
            cx = bx;
            cy = by;
            c = cy * GRID_W + cx;
            open_m[c] = 0;
            closed_m[c] = 1;
            relax_neighbors(cx, cy, r.gx, r.gy);
        end
        if (!(cx == r.gx && cy == r.gy))
        begin
            pt = '{px: 3'd0, py: 3'd0, found: 1'b0, last: 1'b1};
            expected_points.push_back(pt);
            return;
        end
        n_found++;
        npts = 0;
        pts[npts] = goal;
        npts = npts + 1;
        p = parent[goal];
        while (p != start && npts < 64)
        begin
            pts[npts] = p;
            npts = npts + 1;
            p = parent[p];
        end
        for (int k = 0; k < npts; k++)
        begin
            c = pts[npts - 1 - k];
            pt.px = 3'(c % GRID_W);
            pt.py = 3'(c / GRID_W);
            pt.found = 1'b1;
            pt.last = (k == npts - 1);
            expected_points.push_back(pt);
        end
    endfunction

    function automatic request_t write_req(int x, int y, bit f);
        request_t r;
        r = '0;
        r.kind = gbfps_pkg::KIND_WRITE;
        r.cx = 3'(x);
        r.cy = 3'(y);
        r.free = f;
        return r;
    endfunction

    function automatic request_t search_req(int sx, int sy, int gx, int gy);
        request_t r;
        r = '0;
        r.kind = gbfps_pkg::KIND_SEARCH;
        r.sx = 3'(sx);
        r.sy = 3'(sy);
        r.gx = 3'(gx);
        r.gy = 3'(gy);
        return r;
    endfunction

    // send one request, with bursts and gaps on the sender side
    task automatic send_request(request_t r);
        s_axis_tdata <= pack_request(r);
        s_axis_tuser <= r.kind;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if ($urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
        end
    endtask

    // wait for every expected point, then let the block settle
    task automatic drain_points();
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (100)
            @(posedge clk);
    endtask

    // receiver stall pattern: long ready runs and short random stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (cycles % 512 < 128)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 2) != 0);
    end

    // compare each accepted point with the oldest expectation
    always @(posedge clk)
    begin
        point_t exp_pt;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            n_results++;
            if (expected_points.size() == 0)
            begin
                $error("unexpected point %h found %b last %b", m_axis_tdata, m_axis_tuser,
                       m_axis_tlast);
                errors++;
            end
            else
            begin
                exp_pt = expected_points.pop_front();
                if (m_axis_tdata[2:0] !== exp_pt.px)
                begin
                    $error("point_x exp %0d got %0d", exp_pt.px, m_axis_tdata[2:0]);
                    errors++;
                end
                if (m_axis_tdata[5:3] !== exp_pt.py)
                begin
                    $error("point_y exp %0d got %0d", exp_pt.py, m_axis_tdata[5:3]);
                    errors++;
                end
                if (m_axis_tuser !== exp_pt.found)
                begin
                    $error("found exp %0d got %0d", exp_pt.found, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tlast !== exp_pt.last)
                begin
                    $error("last exp %0d got %0d", exp_pt.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYC)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial
    begin
        request_t r;
        point_t pt;
        int sx;
        int sy;
        int before_n;
        errors = 0;
        cycles = 0;
        n_results = 0;
        n_searches = 0;
        n_found = 0;
        foreach (free_map[i])
            free_map[i] = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;

        // directed table; fixed rows hold typed-in results checked against the predictor
        dir_rows[0]  = '{search_req(0, 0, 7, 7), 1, '{0, 0, 1'b0, 1'b1}};
        dir_rows[1]  = '{search_req(3, 3, 3, 3), 1, '{3, 3, 1'b1, 1'b1}};
        dir_rows[2]  = '{write_req(1, 1, 1), 0, '0};
        dir_rows[3]  = '{search_req(0, 0, 1, 1), 1, '{1, 1, 1'b1, 1'b1}};
        dir_rows[4]  = '{write_req(2, 0, 1), 0, '0};
        dir_rows[5]  = '{search_req(0, 0, 2, 0), 0, '0};
        dir_rows[6]  = '{write_req(7, 7, 1), 0, '0};
        dir_rows[7]  = '{write_req(6, 6, 1), 0, '0};
        dir_rows[8]  = '{search_req(6, 6, 7, 7), 1, '{7, 7, 1'b1, 1'b1}};
        dir_rows[9]  = '{search_req(7, 7, 0, 0), 1, '{0, 0, 1'b0, 1'b1}};
        dir_rows[10] = '{write_req(1, 1, 0), 0, '0};
        dir_rows[11] = '{search_req(0, 0, 1, 1), 1, '{0, 0, 1'b0, 1'b1}};
        dir_rows[12] = '{write_req(0, 7, 1), 0, '0};
        dir_rows[13] = '{write_req(7, 0, 1), 0, '0};
        dir_rows[14] = '{search_req(7, 0, 0, 7), 0, '0};
        dir_rows[15] = '{search_req(0, 1, 1, 0), 0, '0};
        dir_rows[16] = '{write_req(0, 0, 0), 0, '0};
        dir_rows[17] = '{search_req(1, 0, 0, 0), 0, '0};
        dir_rows[18] = '{write_req(1, 1, 1), 0, '0};
        dir_rows[19] = '{search_req(0, 0, 6, 6), 0, '0};

        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        repeat (70)
            @(posedge clk);

        // walk the directed table
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            before_n = expected_points.size();
            predict_path(dir_rows[i].req);
            if (dir_rows[i].has_fixed)
            begin
                pt = expected_points[$];
                if (pt !== dir_rows[i].fixed || expected_points.size() != before_n + 1)
                begin
                    $error("table row %0d expected value disagrees with predictor", i);
                    errors++;
                end
            end
            send_request(dir_rows[i].req);
        end

        // random part: mostly open maps with random searches
        for (int i = 0; i < 100; i++)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                r = search_req($urandom_range(0, 7), $urandom_range(0, 7),
                               $urandom_range(0, 7), $urandom_range(0, 7));
            end
            else
            begin
                r = write_req($urandom_range(0, 7), $urandom_range(0, 7),
                              $urandom_range(0, 4) != 0);
                // unused search fields still toggle
                r.sx = 3'($urandom);
                r.sy = 3'($urandom);
                r.gx = 3'($urandom);
                r.gy = 3'($urandom);
            end
            if (r.kind == gbfps_pkg::KIND_SEARCH)
            begin
                r.cx = 3'($urandom);
                r.cy = 3'($urandom);
                r.free = 1'($urandom);
            end
            predict_path(r);
            send_request(r);
        end
        // ten searches toward the mirrored cell (7 - x, 7 - y) to reach long paths
        for (int i = 0; i < 10; i++)
        begin
            sx = $urandom_range(0, 7);
            sy = $urandom_range(0, 7);
            r = search_req(sx, sy, 7 - sx, 7 - sy);
            predict_path(r);
            send_request(r);
        end
        s_axis_tvalid <= 1'b0;
        drain_points();

        $display("searches %0d, paths found %0d, points checked %0d",
                 n_searches, n_found, n_results);
        if (errors == 0 && expected_points.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule
